// ===== rtl/fect_pkg.sv =====
`default_nettype none
package fect_pkg;

  // Table size
  localparam int CHANNELS = 16;
  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(CHANNELS + 1);

  // Command codes
  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_STOP   = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_RALL   = 3'd3;
  localparam logic [2:0] CMD_RPREV  = 3'd4;
  localparam logic [2:0] CMD_SETW   = 3'd5;
  localparam logic [2:0] CMD_TICK   = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;

  // Envelope phases
  localparam logic [1:0] PH_IN   = 2'd0;
  localparam logic [1:0] PH_HOLD = 2'd1;
  localparam logic [1:0] PH_OUT  = 2'd2;

  // Channel flag bits
  localparam int FL_TEMP    = 0;
  localparam int FL_NOTREM  = 1;
  localparam int FL_PREVIEW = 2;
  localparam int FL_IGNORE  = 3;

  typedef struct packed {
    logic [15:0]        id;
    logic [1:0]         phase;
    logic signed [15:0] target;
    logic signed [15:0] level;
    logic [15:0]        fade;
    logic [15:0]        life;
    logic [7:0]         repeats;
    logic [31:0]        start;
    logic [3:0]         flags;
  } slot_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_RALL_INIT,
    OP_RALL_STEP,
    OP_TICK_INIT,
    OP_EVAL,
    OP_MUL1,
    OP_MUL2,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FIN,
    OP_REPORT,
    OP_ACK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   empty_tick;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       n_zero;
    logic       at_end;
    logic       scan_done;
    logic       cur_zero;
    logic       eval_div;
    logic       div_last;
    logic       rep_last;
    logic       out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/fect_ctrl.sv =====
`default_nettype none
module fect_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  fect_pkg::dp_sts_t  sts,
  output fect_pkg::dp_cmd_t  cmd
);
  import fect_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SCAN, ST_RALL, ST_EVAL, ST_MUL1, ST_MUL2,
    ST_DIVINIT, ST_DIV, ST_FIN, ST_REPORT, ST_ACK, ST_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Sequence datapath operations for the latched command
  always_comb begin
    state_nxt      = state_r;
    cmd.op         = OP_NONE;
    cmd.empty_tick = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.cmd)
          CMD_START: begin
            cmd.op    = OP_START;
            state_nxt = ST_ACK;
          end
          CMD_STOP, CMD_REMOVE, CMD_SETW: begin
            cmd.op    = OP_SCAN_INIT;
            state_nxt = ST_SCAN;
          end
          CMD_RALL, CMD_RPREV: begin
            if (sts.n_zero) begin
              state_nxt = ST_ACK;
            end else begin
              cmd.op    = OP_RALL_INIT;
              state_nxt = ST_RALL;
            end
          end
          CMD_TICK: begin
            cmd.op    = OP_TICK_INIT;
            state_nxt = sts.n_zero ? ST_EMPTY : ST_EVAL;
          end
          default: state_nxt = ST_ACK;
        endcase
      end
      ST_SCAN: begin
        if (sts.scan_done || sts.at_end) begin
          state_nxt = ST_ACK;
        end else begin
          cmd.op = OP_SCAN_STEP;
        end
      end
      ST_RALL: begin
        cmd.op = OP_RALL_STEP;
        if (sts.cur_zero) state_nxt = ST_ACK;
      end
      ST_EVAL: begin
        cmd.op    = OP_EVAL;
        state_nxt = sts.eval_div ? ST_MUL1 : ST_REPORT;
      end
      ST_MUL1: begin
        cmd.op    = OP_MUL1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op    = OP_MUL2;
        state_nxt = ST_DIVINIT;
      end
      ST_DIVINIT: begin
        cmd.op    = OP_DIV_INIT;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          cmd.op    = OP_REPORT;
          state_nxt = sts.rep_last ? ST_IDLE : ST_EVAL;
        end
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.op    = OP_ACK;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.op         = OP_ACK;
          cmd.empty_tick = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fect_dp.sv =====
`default_nettype none
module fect_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  fect_pkg::dp_cmd_t   cmd,
  output fect_pkg::dp_sts_t   sts,
  input  wire  [2:0]          in_command,
  input  wire  [15:0]         in_channel_id,
  input  wire  signed [15:0]  in_weight,
  input  wire  [15:0]         in_fade_ms,
  input  wire  [15:0]         in_life_ms,
  input  wire  [7:0]          in_repeat_count,
  input  wire  [31:0]         in_now_ms,
  input  wire                 in_temporary,
  input  wire                 in_not_removable,
  input  wire                 in_preview,
  input  wire                 in_ignore_life,
  input  wire                 cfg_valid,
  input  wire  [14:0]         cfg_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          out_kind,
  output logic [1:0]          out_status,
  output logic [15:0]         out_report_id,
  output logic signed [15:0]  out_current_weight,
  output logic [1:0]          out_phase,
  output logic                out_dropped,
  output logic                out_last
);
  import fect_pkg::*;

  slot_t slots_r [CHANNELS];

  // Latched command item
  logic [2:0]         cmd_r;
  logic [15:0]        cid_r;
  logic signed [15:0] w_r;
  logic [15:0]        fade_r, life_r;
  logic [7:0]         rep_r;
  logic [31:0]        now_r;
  logic [3:0]         flags_r;

  // Control registers
  logic [CW-1:0] n_r, n_nxt, cur_r, cur_nxt;
  logic [15:0]   next_id_r, next_id_nxt, ack_id_r, ack_id_nxt;
  logic [31:0]   last_tick_r, last_tick_nxt;
  logic [14:0]   limit_r;
  logic [1:0]    sts_r, sts_nxt;
  logic          done_r, done_nxt, drop_r, drop_nxt;

  // Fade arithmetic
  logic [15:0] e16_r, f16_r, mag_r, q_r, lo_r;
  logic        neg_r;
  logic [1:0]  ph_r;
  logic [31:0] esq_r, fsq_r, rem_r;
  logic [47:0] num_r;
  logic [3:0]  cnt_r;

  // Output register
  logic               ov_r, ov_nxt;
  logic [1:0]         okind_r, osts_r, oph_r;
  logic [15:0]        oid_r;
  logic signed [15:0] olvl_r;
  logic               odrop_r, olast_r;
  logic               emit;

  // Slot write / drop controls
  logic          do_wr, do_drop;
  logic [IW-1:0] wr_idx, drop_idx, idx;
  slot_t         sl, wr_val;

  logic [31:0] e;
  logic [15:0] fnz;
  logic        fading, e_ge_f, match, quiet;
  logic [16:0] lmag, tmag, qs, lvl17;
  logic [32:0] dtry;

  assign idx = cur_r[IW-1:0];
  assign sl  = slots_r[idx];

  // Per-slot evaluation terms
  always_comb begin
    e      = now_r - sl.start;
    fnz    = (sl.fade == 16'd0) ? 16'd1 : sl.fade;
    fading = (sl.phase == PH_IN) || (sl.phase == PH_OUT);
    e_ge_f = (e >= {16'd0, fnz});
    match  = (sl.id == cid_r);
    lmag   = sl.level[15] ? (17'd0 - {1'b1, sl.level}) : {1'b0, sl.level};
    tmag   = sl.target[15] ? (17'd0 - {1'b1, sl.target}) : {1'b0, sl.target};
    quiet  = (lmag <= {2'd0, limit_r});
    qs     = neg_r ? (17'd0 - {1'b0, q_r}) : {1'b0, q_r};
    lvl17  = (ph_r == PH_IN) ? qs : ({sl.target[15], sl.target} - qs);
    dtry   = {rem_r, lo_r[15]};
  end

  assign sts.cmd       = cmd_r;
  assign sts.n_zero    = (n_r == '0);
  assign sts.at_end    = (cur_r == n_r);
  assign sts.scan_done = done_r;
  assign sts.cur_zero  = (cur_r == '0);
  assign sts.eval_div  = fading && !e_ge_f;
  assign sts.div_last  = (cnt_r == 4'd0);
  assign sts.rep_last  = (cur_r == n_r - CW'(1));
  assign sts.out_free  = !(ov_r && out_stall);

  // Decide control updates and the slot write for this operation
  always_comb begin
    n_nxt         = n_r;
    cur_nxt       = cur_r;
    next_id_nxt   = next_id_r;
    ack_id_nxt    = ack_id_r;
    last_tick_nxt = last_tick_r;
    sts_nxt       = sts_r;
    done_nxt      = done_r;
    drop_nxt      = drop_r;
    do_wr         = 1'b0;
    do_drop       = 1'b0;
    wr_idx        = idx;
    drop_idx      = idx;
    wr_val        = sl;
    emit          = (cmd.op == OP_REPORT) || (cmd.op == OP_ACK);
    case (cmd.op)
      OP_LOAD: begin
        sts_nxt    = STS_OK;
        ack_id_nxt = 16'd0;
      end
      OP_START: begin
        if (n_r == CW'(CHANNELS)) begin
          sts_nxt = STS_FULL;
        end else begin
          do_wr          = 1'b1;
          wr_idx         = n_r[IW-1:0];
          wr_val.id      = next_id_r;
          wr_val.phase   = PH_IN;
          wr_val.target  = w_r;
          wr_val.level   = w_r;
          wr_val.fade    = fade_r;
          wr_val.life    = life_r;
          wr_val.repeats = rep_r;
          wr_val.start   = last_tick_r;
          wr_val.flags   = flags_r;
          ack_id_nxt     = next_id_r;
          next_id_nxt    = next_id_r + 16'd1;
          n_nxt          = n_r + CW'(1);
        end
      end
      OP_SCAN_INIT: begin
        cur_nxt  = '0;
        sts_nxt  = STS_NOTFOUND;
        done_nxt = 1'b0;
      end
      OP_SCAN_STEP: begin
        cur_nxt = cur_r + CW'(1);
        if (match) begin
          sts_nxt = STS_OK;
          case (cmd_r)
            CMD_STOP: begin
              if (quiet || sl.fade == 16'd0) begin
                done_nxt = 1'b1;
                if (!sl.flags[FL_NOTREM]) begin
                  do_drop = 1'b1;
                  n_nxt   = n_r - CW'(1);
                end
              end else begin
                do_wr        = 1'b1;
                wr_val.fade  = fade_r;
                wr_val.phase = PH_OUT;
                wr_val.start = last_tick_r;
              end
            end
            CMD_REMOVE: begin
              done_nxt = 1'b1;
              do_drop  = 1'b1;
              n_nxt    = n_r - CW'(1);
            end
            default: begin
              done_nxt      = 1'b1;
              do_wr         = 1'b1;
              wr_val.target = w_r;
            end
          endcase
        end
      end
      OP_RALL_INIT: begin
        cur_nxt = n_r - CW'(1);
      end
      OP_RALL_STEP: begin
        cur_nxt = cur_r - CW'(1);
        if (!sl.flags[FL_NOTREM] && (cmd_r == CMD_RALL || sl.flags[FL_PREVIEW])) begin
          do_drop = 1'b1;
          n_nxt   = n_r - CW'(1);
        end
      end
      OP_TICK_INIT: begin
        last_tick_nxt = now_r;
        cur_nxt       = '0;
      end
      OP_EVAL: begin
        do_wr    = 1'b1;
        drop_nxt = sl.flags[FL_TEMP];
        if (fading) begin
          wr_val.fade = fnz;
          if (sl.phase == PH_IN) begin
            if (e_ge_f) begin
              wr_val.phase = PH_HOLD;
              wr_val.start = now_r;
              wr_val.level = sl.target;
            end
          end else if (e_ge_f) begin
            wr_val.level = 16'sd0;
            if (sl.repeats == 8'd0) begin
              drop_nxt = 1'b1;
            end else begin
              wr_val.repeats = sl.repeats - 8'd1;
              wr_val.start   = now_r;
              wr_val.phase   = PH_IN;
            end
          end
        end else begin
          wr_val.level = sl.target;
          if (!sl.flags[FL_IGNORE] && sl.life != 16'd0 && e >= {16'd0, sl.life}) begin
            wr_val.phase = PH_OUT;
            wr_val.start = now_r;
          end
        end
      end
      OP_FIN: begin
        do_wr        = 1'b1;
        wr_val.level = lvl17[15:0];
      end
      OP_REPORT: begin
        if (drop_r) begin
          do_drop = 1'b1;
          n_nxt   = n_r - CW'(1);
        end else begin
          cur_nxt = cur_r + CW'(1);
        end
      end
      default: ;
    endcase
    ov_nxt = emit ? 1'b1 : (ov_r && out_stall);
  end

  // Slot storage: write one entry or close the gap of a dropped one
  always_ff @(posedge clk) begin
    for (int j = 0; j < CHANNELS; j++) begin
      if (do_wr && wr_idx == IW'(j)) slots_r[j] <= wr_val;
    end
    if (do_drop) begin
      for (int j = 0; j < CHANNELS - 1; j++) begin
        if (IW'(j) >= drop_idx) slots_r[j] <= slots_r[j + 1];
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      cur_r       <= '0;
      next_id_r   <= 16'd0;
      last_tick_r <= 32'd0;
      limit_r     <= 15'd1;
      done_r      <= 1'b0;
      drop_r      <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      cur_r       <= cur_nxt;
      next_id_r   <= next_id_nxt;
      last_tick_r <= last_tick_nxt;
      done_r      <= done_nxt;
      drop_r      <= drop_nxt;
      ov_r        <= ov_nxt;
      if (cfg_valid) limit_r <= cfg_data;
    end
  end

  // Payload: latched item, fade arithmetic and output fields
  always_ff @(posedge clk) begin
    sts_r    <= sts_nxt;
    ack_id_r <= ack_id_nxt;
    if (cmd.op == OP_LOAD) begin
      cmd_r   <= in_command;
      cid_r   <= in_channel_id;
      w_r     <= in_weight;
      fade_r  <= in_fade_ms;
      life_r  <= in_life_ms;
      rep_r   <= in_repeat_count;
      now_r   <= in_now_ms;
      flags_r <= {in_ignore_life, in_preview, in_not_removable, in_temporary};
    end
    if (cmd.op == OP_EVAL) begin
      e16_r <= e[15:0];
      f16_r <= fnz;
      mag_r <= tmag[15:0];
      neg_r <= sl.target[15];
      ph_r  <= sl.phase;
    end
    if (cmd.op == OP_MUL1) begin
      esq_r <= e16_r * e16_r;
      fsq_r <= f16_r * f16_r;
    end
    if (cmd.op == OP_MUL2) num_r <= mag_r * esq_r;
    if (cmd.op == OP_DIV_INIT) begin
      rem_r <= num_r[47:16];
      lo_r  <= num_r[15:0];
      q_r   <= 16'd0;
      cnt_r <= 4'd15;
    end
    // Restoring division, one quotient bit a cycle
    if (cmd.op == OP_DIV_STEP) begin
      if (dtry >= {1'b0, fsq_r}) begin
        rem_r <= 32'(dtry - {1'b0, fsq_r});
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= dtry[31:0];
        q_r   <= {q_r[14:0], 1'b0};
      end
      lo_r  <= {lo_r[14:0], 1'b0};
      cnt_r <= cnt_r - 4'd1;
    end
    if (cmd.op == OP_REPORT) begin
      okind_r <= KIND_REPORT;
      osts_r  <= STS_OK;
      oid_r   <= sl.id;
      olvl_r  <= sl.level;
      oph_r   <= sl.phase;
      odrop_r <= drop_r;
      olast_r <= sts.rep_last;
    end
    if (cmd.op == OP_ACK) begin
      okind_r <= cmd.empty_tick ? KIND_EMPTY : KIND_ACK;
      osts_r  <= cmd.empty_tick ? STS_OK : sts_r;
      oid_r   <= cmd.empty_tick ? 16'd0 : ack_id_r;
      olvl_r  <= 16'sd0;
      oph_r   <= PH_IN;
      odrop_r <= 1'b0;
      olast_r <= 1'b1;
    end
  end

  assign out_valid          = ov_r;
  assign out_kind           = okind_r;
  assign out_status         = osts_r;
  assign out_report_id      = oid_r;
  assign out_current_weight = olvl_r;
  assign out_phase          = oph_r;
  assign out_dropped        = odrop_r;
  assign out_last           = olast_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(CHANNELS))
    else $error("channel count beyond table size");
  a_full_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_START && n_r == CW'(CHANNELS)) |=> n_r == $past(n_r))
    else $error("start on full table changed the count");
  a_report_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_REPORT && drop_r) |=> (n_r == $past(n_r) - CW'(1)) && $stable(cur_r))
    else $error("dropped report did not close the gap");
`endif

endmodule
`default_nettype wire

// ===== rtl/fade_envelope_channel_table.sv =====
`default_nettype none
// Envelope channel table with up to fect_pkg::CHANNELS channels kept in start
// order. One command is taken at a time; in_stall stays high until every
// result of it has been handed to the output register. Stop, remove, set
// weight and the remove-all commands scan the table one channel per cycle. A
// tick evaluates each channel in turn; a channel that is mid-fade also goes
// through two multiply stages and a restoring divider that forms
// target*elapsed^2/fade^2. Output stalls hold back every result.
// The quiet level written on the cfg channel is used by later stop commands.
module fade_envelope_channel_table (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [2:0]          in_command,
  input  wire  [15:0]         in_channel_id,
  input  wire  signed [15:0]  in_weight,
  input  wire  [15:0]         in_fade_ms,
  input  wire  [15:0]         in_life_ms,
  input  wire  [7:0]          in_repeat_count,
  input  wire  [31:0]         in_now_ms,
  input  wire                 in_temporary,
  input  wire                 in_not_removable,
  input  wire                 in_preview,
  input  wire                 in_ignore_life,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          out_kind,
  output logic [1:0]          out_status,
  output logic [15:0]         out_report_id,
  output logic signed [15:0]  out_current_weight,
  output logic [1:0]          out_phase,
  output logic                out_dropped,
  output logic                out_last,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [14:0]         cfg_data
);
  import fect_pkg::*;

  dp_cmd_t dcmd;
  dp_sts_t dsts;

  assign cfg_ready = 1'b1;

  fect_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dsts),
    .cmd      (dcmd)
  );

  fect_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dcmd),
    .sts                (dsts),
    .in_command         (in_command),
    .in_channel_id      (in_channel_id),
    .in_weight          (in_weight),
    .in_fade_ms         (in_fade_ms),
    .in_life_ms         (in_life_ms),
    .in_repeat_count    (in_repeat_count),
    .in_now_ms          (in_now_ms),
    .in_temporary       (in_temporary),
    .in_not_removable   (in_not_removable),
    .in_preview         (in_preview),
    .in_ignore_life     (in_ignore_life),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_status         (out_status),
    .out_report_id      (out_report_id),
    .out_current_weight (out_current_weight),
    .out_phase          (out_phase),
    .out_dropped        (out_dropped),
    .out_last           (out_last)
  );

endmodule
`default_nettype wire

// ===== tb/tb_fade_envelope_channel_table.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_fade_envelope_channel_table;
  import fect_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] CMD_UNDEF = 3'd7;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        channel_id;
    logic signed [15:0] weight;
    logic [15:0]        fade_ms;
    logic [15:0]        life_ms;
    logic [7:0]         repeat_count;
    logic [31:0]        now_ms;
    logic               temporary;
    logic               not_removable;
    logic               preview;
    logic               ignore_life;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [15:0]        report_id;
    logic signed [15:0] current_weight;
    logic [1:0]         phase;
    logic               dropped;
    logic               last;
  } envelope_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  envelope_result_t seen;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;

  cmd_item_t pending_cmds[$];
  envelope_result_t expected_results[$];
  int mismatches = 0;
  int accepted_cmds = 0;
  int result_count = 0;
  int report_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit feeding = 1'b0;

  // channel table mirror
  slot_t tbl[CHANNELS];
  int tbl_used = 0;
  logic [15:0] id_counter = '0;
  logic [31:0] tick_time = '0;
  logic [14:0] quiet_limit = 15'd1;

  always #10 clk = ~clk;

  fade_envelope_channel_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_item.command), .in_channel_id(in_item.channel_id),
    .in_weight(in_item.weight), .in_fade_ms(in_item.fade_ms),
    .in_life_ms(in_item.life_ms), .in_repeat_count(in_item.repeat_count),
    .in_now_ms(in_item.now_ms), .in_temporary(in_item.temporary),
    .in_not_removable(in_item.not_removable), .in_preview(in_item.preview),
    .in_ignore_life(in_item.ignore_life),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(seen.kind), .out_status(seen.status),
    .out_report_id(seen.report_id), .out_current_weight(seen.current_weight),
    .out_phase(seen.phase), .out_dropped(seen.dropped), .out_last(seen.last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // append to the expected result queue
  function automatic void queue_result(envelope_result_t r);
    expected_results = {expected_results, r};
  endfunction

  // append to the pending command queue
  function automatic void queue_cmd(cmd_item_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic envelope_result_t ack(logic [1:0] sts, logic [15:0] rid);
    envelope_result_t r;
    r = '0;
    r.kind = KIND_ACK;
    r.status = sts;
    r.report_id = rid;
    r.last = 1'b1;
    return r;
  endfunction

  // |t| * e^2 / f^2 truncated, sign of t restored
  function automatic logic signed [15:0] fade_share(logic signed [15:0] t,
                                                     logic [31:0] e, logic [15:0] f);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (t < 0) ? 128'(-int'(t)) : 128'(int'(t));
    q = mag * e * e / (128'(f) * f);
    return (t < 0) ? -16'(q) : 16'(q);
  endfunction

  function automatic void shift_out(int idx);
    for (int j = idx; j + 1 < tbl_used; j++) tbl[j] = tbl[j + 1];
    tbl_used--;
  endfunction

  function automatic int find_channel(logic [15:0] cid);
    for (int i = 0; i < tbl_used; i++) if (tbl[i].id == cid) return i;
    return -1;
  endfunction

  // advance the mirror and queue the expected results of one command
  function automatic void predict_envelope(cmd_item_t c);
    envelope_result_t r;
    int s;
    int total;
    int i;
    int k;
    bit found;
    bit drop;
    logic [31:0] e;
    logic [15:0] mag;
    case (c.command)
      CMD_START: begin
        if (tbl_used >= CHANNELS) begin
          queue_result(ack(STS_FULL, 16'd0));
        end else begin
          tbl[tbl_used] = '{id: id_counter, phase: PH_IN, target: c.weight,
            level: c.weight, fade: c.fade_ms, life: c.life_ms,
            repeats: c.repeat_count, start: tick_time,
            flags: {c.ignore_life, c.preview, c.not_removable, c.temporary}};
          tbl_used++;
          queue_result(ack(STS_OK, id_counter));
          id_counter++;
        end
      end
      CMD_STOP: begin
        found = 1'b0;
        for (i = 0; i < tbl_used; i++) begin
          if (tbl[i].id != c.channel_id) continue;
          found = 1'b1;
          mag = (tbl[i].level < 0) ? -tbl[i].level : tbl[i].level;
          if (mag <= quiet_limit || tbl[i].fade == 0) begin
            if (!tbl[i].flags[FL_NOTREM]) shift_out(i);
            break;
          end
          tbl[i].fade = c.fade_ms;
          tbl[i].phase = PH_OUT;
          tbl[i].start = tick_time;
        end
        queue_result(ack(found ? STS_OK : STS_NOTFOUND, 16'd0));
      end
      CMD_REMOVE, CMD_SETW: begin
        s = find_channel(c.channel_id);
        if (s >= 0) begin
          if (c.command == CMD_REMOVE) shift_out(s);
          else tbl[s].target = c.weight;
        end
        queue_result(ack(s >= 0 ? STS_OK : STS_NOTFOUND, 16'd0));
      end
      CMD_RALL, CMD_RPREV: begin
        for (i = tbl_used - 1; i >= 0; i--) begin
          if (tbl[i].flags[FL_NOTREM]) continue;
          if (c.command == CMD_RPREV && !tbl[i].flags[FL_PREVIEW]) continue;
          shift_out(i);
        end
        queue_result(ack(STS_OK, 16'd0));
      end
      CMD_TICK: begin
        tick_time = c.now_ms;
        total = tbl_used;
        if (total == 0) begin
          r = '0;
          r.kind = KIND_EMPTY;
          r.last = 1'b1;
          queue_result(r);
        end
        i = 0;
        k = 0;
        while (i < tbl_used) begin
          e = c.now_ms - tbl[i].start;
          drop = 1'b0;
          if (tbl[i].phase != PH_HOLD) begin
            if (tbl[i].fade == 0) tbl[i].fade = 16'd1;
            if (tbl[i].phase == PH_IN) begin
              if (e >= tbl[i].fade) begin
                tbl[i].phase = PH_HOLD;
                tbl[i].start = c.now_ms;
                tbl[i].level = tbl[i].target;
              end else begin
                tbl[i].level = fade_share(tbl[i].target, e, tbl[i].fade);
              end
            end else if (e >= tbl[i].fade) begin
              tbl[i].level = '0;
              if (tbl[i].repeats == 0) begin
                drop = 1'b1;
              end else begin
                tbl[i].repeats--;
                tbl[i].start = c.now_ms;
                tbl[i].phase = PH_IN;
              end
            end else begin
              tbl[i].level = tbl[i].target - fade_share(tbl[i].target, e, tbl[i].fade);
            end
          end else begin
            tbl[i].level = tbl[i].target;
            if (!tbl[i].flags[FL_IGNORE] && tbl[i].life != 0 && e >= tbl[i].life) begin
              tbl[i].phase = PH_OUT;
              tbl[i].start = c.now_ms;
            end
          end
          if (tbl[i].flags[FL_TEMP]) drop = 1'b1;
          r = '0;
          r.kind = KIND_REPORT;
          r.report_id = tbl[i].id;
          r.current_weight = tbl[i].level;
          r.phase = tbl[i].phase;
          r.dropped = drop;
          r.last = (k == total - 1);
          queue_result(r);
          k++;
          if (drop) shift_out(i);
          else i++;
        end
      end
      default: queue_result(ack(STS_OK, 16'd0));
    endcase
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive command transfers
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_envelope(in_item);
        accepted_cmds++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (feeding && pending_cmds.size() > 0) begin
          in_item <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          send_gap <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // check result transfers and pace the output stall
  always @(posedge clk) begin
    envelope_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (seen.kind == KIND_REPORT) report_count++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", seen);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, seen);
          end
        end
      end
      // hold a stall run, or start a new one now and then
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        stall_left <= gap_len();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !feeding) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cmd_item_t blank_cmd(logic [2:0] op);
    cmd_item_t c;
    c = '0;
    c.command = op;
    return c;
  endfunction

  function automatic cmd_item_t start_cmd(logic signed [15:0] w, logic [15:0] f,
                                         logic [15:0] l, logic [7:0] rep, logic [3:0] fl);
    cmd_item_t c;
    c = blank_cmd(CMD_START);
    c.weight = w;
    c.fade_ms = f;
    c.life_ms = l;
    c.repeat_count = rep;
    {c.ignore_life, c.preview, c.not_removable, c.temporary} = fl;
    return c;
  endfunction

  function automatic cmd_item_t random_cmd(logic [31:0] t, logic [15:0] idbase);
    cmd_item_t c;
    logic [159:0] raw;
    int p;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cmd_item_t)-1:0];
    p = $urandom_range(0, 99);
    if (p < 30) c.command = CMD_START;
    else if (p < 40) c.command = CMD_STOP;
    else if (p < 46) c.command = CMD_REMOVE;
    else if (p < 48) c.command = CMD_RALL;
    else if (p < 51) c.command = CMD_RPREV;
    else if (p < 57) c.command = CMD_SETW;
    else if (p < 59) c.command = CMD_UNDEF;
    else c.command = CMD_TICK;
    // mostly address live ids, short fades and lives, few repeats
    if ($urandom_range(0, 9) < 8) c.channel_id = idbase + 16'($urandom_range(0, 20));
    if ($urandom_range(0, 9) < 8) c.fade_ms = 16'($urandom_range(0, 60));
    if ($urandom_range(0, 9) < 7) c.life_ms = 16'($urandom_range(0, 80));
    if ($urandom_range(0, 9) < 8) c.repeat_count = 8'($urandom_range(0, 2));
    if ($urandom_range(0, 9) < 8) c.now_ms = t;
    if ($urandom_range(0, 3) != 0) c.temporary = 1'b0;
    return c;
  endfunction

  // load one register value while the block is idle
  task automatic write_quiet(logic [14:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    quiet_limit = v;
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    logic [31:0] t;
    logic [14:0] limits[4];
    limits = '{15'd1, 15'd0, 15'd32767, 15'd2000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every command, special cases
    queue_cmd(blank_cmd(CMD_TICK));
    queue_cmd(start_cmd(16'sh7fff, 16'd0, 16'd0, 8'd0, 4'b0000));
    queue_cmd(start_cmd(-16'sh8000, 16'hffff, 16'hffff, 8'hff, 4'b1110));
    queue_cmd(start_cmd(16'sd0, 16'd10, 16'd5, 8'd1, 4'b0001));
    queue_cmd(start_cmd(16'sd4096, 16'd20, 16'd30, 8'd0, 4'b0100));
    for (int k = 0; k < 3; k++) begin
      cmd_item_t c;
      c = blank_cmd(CMD_TICK);
      c.now_ms = (k == 2) ? 32'hffff_fff0 : 32'd7 * (k + 1);
      queue_cmd(c);
    end
    begin
      cmd_item_t c;
      c = blank_cmd(CMD_STOP); c.channel_id = 16'd1; c.fade_ms = 16'd9;
      queue_cmd(c);
      c = blank_cmd(CMD_STOP); c.channel_id = 16'hffff;
      queue_cmd(c);
      c = blank_cmd(CMD_SETW); c.channel_id = 16'd3; c.weight = -16'sd300;
      queue_cmd(c);
      c = blank_cmd(CMD_REMOVE); c.channel_id = 16'd3;
      queue_cmd(c);
      c = blank_cmd(CMD_REMOVE); c.channel_id = 16'd3;
      queue_cmd(c);
      queue_cmd(blank_cmd(CMD_UNDEF));
      c = blank_cmd(CMD_TICK); c.now_ms = 32'd5;
      queue_cmd(c);
      queue_cmd(blank_cmd(CMD_RPREV));
      queue_cmd(blank_cmd(CMD_RALL));
      for (int k = 0; k < 17; k++) queue_cmd(start_cmd(16'sd100, 16'd3,
                                              16'd0, 8'd0, 4'b0000));
      c = blank_cmd(CMD_TICK); c.now_ms = 32'd100;
      queue_cmd(c);
      queue_cmd(blank_cmd(CMD_RALL));
    end
    feeding = 1'b1;
    drain();

    // random phases, one quiet limit each
    t = 32'd200;
    for (int ph = 0; ph < 4; ph++) begin
      feeding = 1'b0;
      write_quiet(limits[ph]);
      for (int k = 0; k < 24; k++) begin
        t += $urandom_range(0, 25);
        queue_cmd(random_cmd(t, id_counter > 16'd10 ? id_counter - 16'd10 : 16'd0));
      end
      feeding = 1'b1;
      drain();
    end

    $display("Covered %0d commands, %0d results of which %0d channel reports.",
             accepted_cmds, result_count, report_count);
    $display("Quiet limit swept over 0, 1, 2000 and 32767 with random stalls.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
